// ===== rtl/bfgl_pkg.sv =====
// Package for the bitmap font glyph layout block.
// Holds character codes, field widths and the command and status structs
// shared by the controller, the datapath and the top level.
package bfgl_pkg;

    localparam int CHAR_W      = 8;
    localparam int COORD_W     = 16;
    localparam int SIZE_W      = 8;
    localparam int SCALE_W     = 12;
    localparam int IDX_W       = 7;
    localparam int REG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int DIV_STEPS   = IDX_W;
    localparam int STEP_CNT_W  = 3;

    localparam int S_DATA_W    = CHAR_W + 2 * COORD_W;
    localparam int M_DATA_W    = 6 * COORD_W + 2 * SIZE_W;

    localparam logic [CHAR_W-1:0] FIRST_CHAR   = 8'd32;
    localparam logic [CHAR_W-1:0] LAST_CHAR    = 8'd126;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    localparam logic [REG_IDX_W-1:0] REG_GLYPH_WIDTH   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GLYPH_HEIGHT  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ATLAS_COLUMNS = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SCALE         = 2'd3;

    localparam logic [SIZE_W-1:0]  RST_GLYPH_WIDTH   = 8'd8;
    localparam logic [SIZE_W-1:0]  RST_GLYPH_HEIGHT  = 8'd8;
    localparam logic [SIZE_W-1:0]  RST_ATLAS_COLUMNS = 8'd16;
    localparam logic [SCALE_W-1:0] RST_SCALE         = 12'd256;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic apply;
    } bfgl_cmd_t;

    typedef struct packed {
        logic printable;
        logic out_free;
    } bfgl_sts_t;

endpackage

// ===== rtl/bfgl_ctrl.sv =====
// Controller state machine of the bitmap font glyph layout block.
// Sequences accept, divider steps, multiply and apply; uses bfgl_pkg.
module bfgl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bfgl_pkg::bfgl_sts_t   sts,
    output bfgl_pkg::bfgl_cmd_t   cmd
);
    import bfgl_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;
    localparam logic [1:0] ST_APPLY = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [STEP_CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (!sts.printable || sts.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/bfgl_dp.sv =====
// Datapath of the bitmap font glyph layout block: configuration registers,
// pen state, shift-subtract divider, multipliers and output register.
// Uses bfgl_pkg; driven by bfgl_ctrl commands.
module bfgl_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bfgl_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [bfgl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [bfgl_pkg::S_DATA_W-1:0]     in_data,
    input  logic                              in_start,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bfgl_pkg::M_DATA_W-1:0]     out_data,
    input  bfgl_pkg::bfgl_cmd_t               cmd,
    output bfgl_pkg::bfgl_sts_t               sts
);
    import bfgl_pkg::*;

    logic [SIZE_W-1:0]   gw_reg;
    logic [SIZE_W-1:0]   gh_reg;
    logic [SIZE_W-1:0]   cols_reg;
    logic [SCALE_W-1:0]  scale_reg;

    logic signed [COORD_W-1:0] pen_x_reg;
    logic signed [COORD_W-1:0] pen_y_reg;
    logic signed [COORD_W-1:0] line_x_reg;
    logic signed [COORD_W-1:0] pen_x_next;
    logic signed [COORD_W-1:0] pen_y_next;
    logic signed [COORD_W-1:0] line_x_next;

    logic [CHAR_W-1:0]   char_reg;
    logic [SIZE_W-1:0]   div_reg;
    logic [SIZE_W-1:0]   rem_reg;
    logic [IDX_W-1:0]    quo_reg;
    logic [SIZE_W:0]     trial;
    logic [SIZE_W:0]     diff;

    logic [COORD_W-1:0]  sw_reg;
    logic [COORD_W-1:0]  sh_reg;
    logic [COORD_W-1:0]  src_x_reg;
    logic [COORD_W-1:0]  src_y_reg;
    logic [SIZE_W+SCALE_W-1:0] sw_prod;
    logic [SIZE_W+SCALE_W-1:0] sh_prod;

    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;

    logic is_nl;
    logic is_sp;
    logic is_pr;
    logic [CHAR_W-1:0]    in_char;
    logic [CHAR_W-1:0]    in_idx;
    logic signed [COORD_W+1:0] x_sum;
    logic signed [COORD_W+1:0] y_sum;
    logic signed [COORD_W-1:0] x_sat;
    logic signed [COORD_W-1:0] y_sat;

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [COORD_W+1:0] v);
        logic signed [COORD_W+1:0] hi;
        logic signed [COORD_W+1:0] lo;
        hi = (COORD_W+2)'(32767);
        lo = -(COORD_W+2)'(32768);
        if (v > hi)
        begin
            return 16'sh7FFF;
        end
        else if (v < lo)
        begin
            return 16'sh8000;
        end
        return v[COORD_W-1:0];
    endfunction

    assign in_char = in_data[CHAR_W-1:0];
    assign in_idx  = in_char - FIRST_CHAR;

    assign is_nl = (char_reg == NEWLINE_CODE);
    assign is_sp = !is_nl && (char_reg == FIRST_CHAR);
    assign is_pr = !is_nl && (char_reg > FIRST_CHAR) && (char_reg <= LAST_CHAR);

    assign trial = {rem_reg, quo_reg[IDX_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    assign sw_prod = SIZE_W'(gw_reg) * (SIZE_W+SCALE_W)'(scale_reg);
    assign sh_prod = SIZE_W'(gh_reg) * (SIZE_W+SCALE_W)'(scale_reg);

    assign x_sum = {{2{pen_x_reg[COORD_W-1]}}, pen_x_reg} + {2'b00, sw_reg};
    assign y_sum = {{2{pen_y_reg[COORD_W-1]}}, pen_y_reg} + {2'b00, sh_reg};
    assign x_sat = sat16(x_sum);
    assign y_sat = sat16(y_sum);

    assign sts.printable = is_pr;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

    always_comb
    begin
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        line_x_next = line_x_reg;
        if (cmd.load && in_start)
        begin
            pen_x_next  = in_data[CHAR_W +: COORD_W];
            line_x_next = in_data[CHAR_W +: COORD_W];
            pen_y_next  = in_data[CHAR_W+COORD_W +: COORD_W];
        end
        else if (cmd.apply)
        begin
            if (is_nl)
            begin
                pen_x_next = line_x_reg;
                pen_y_next = y_sat;
            end
            else if (is_sp || is_pr)
            begin
                pen_x_next = x_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg        <= RST_GLYPH_WIDTH;
            gh_reg        <= RST_GLYPH_HEIGHT;
            cols_reg      <= RST_ATLAS_COLUMNS;
            scale_reg     <= RST_SCALE;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            line_x_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GLYPH_WIDTH:   gw_reg    <= cfg_data[SIZE_W-1:0];
                    REG_GLYPH_HEIGHT:  gh_reg    <= cfg_data[SIZE_W-1:0];
                    REG_ATLAS_COLUMNS: cols_reg  <= cfg_data[SIZE_W-1:0];
                    REG_SCALE:         scale_reg <= cfg_data[SCALE_W-1:0];
                    default:           gw_reg    <= gw_reg;
                endcase
            end
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            line_x_reg <= line_x_next;
            if (cmd.apply && is_pr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg <= in_char;
            quo_reg  <= in_idx[IDX_W-1:0];
            rem_reg  <= '0;
            div_reg  <= (cols_reg == '0) ? SIZE_W'(1) : cols_reg;
        end
        else if (cmd.div_step)
        begin
            if (!diff[SIZE_W])
            begin
                rem_reg <= diff[SIZE_W-1:0];
                quo_reg <= {quo_reg[IDX_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[SIZE_W-1:0];
                quo_reg <= {quo_reg[IDX_W-2:0], 1'b0};
            end
        end
        if (cmd.mul)
        begin
            sw_reg    <= sw_prod[SIZE_W+SCALE_W-1:4];
            sh_reg    <= sh_prod[SIZE_W+SCALE_W-1:4];
            src_x_reg <= COORD_W'(rem_reg[IDX_W-1:0]) * COORD_W'(gw_reg);
            src_y_reg <= COORD_W'(quo_reg) * COORD_W'(gh_reg);
        end
        if (cmd.apply && is_pr)
        begin
            out_data_reg <= {sh_reg, sw_reg, pen_y_reg, pen_x_reg,
                             gh_reg, gw_reg, src_y_reg, src_x_reg};
        end
    end

endmodule

// ===== rtl/bitmap_font_glyph_layout_top.sv =====
// Top level of the bitmap font glyph layout block.
// Joins bfgl_ctrl and bfgl_dp; uses bfgl_pkg.
//
// The block takes one text character per input beat and keeps a pen cursor
// and a line start in signed Q12.4. A printable character produces one
// output beat with its atlas source rectangle and its scaled screen
// rectangle; newline and space only move the pen, and other codes do nothing.
// Input beats arrive on s_t*, with start_of_text on s_tuser, which loads the
// origin before the character is handled. Results leave on m_t*.
// Registers are to be written through cfg_we, cfg_index and cfg_data only
// while the block is idle; the block itself does not enforce this.
// Each character passes through an accept step, seven steps of the
// shift-subtract divider for atlas row and column, a step for the multipliers
// and a step to update the pen and load the output register. The next beat
// may be accepted while a result still waits in the output register; if the
// receiver stalls, the following printable character waits in its final step
// until the register frees. Reset clears the pen, the line start and the
// output valid and loads the register defaults.
module bitmap_font_glyph_layout_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // char_code [7:0], origin_x [23:8], origin_y [39:24]
    input  logic [bfgl_pkg::S_DATA_W-1:0]      s_tdata,
    // start_of_text [0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // src_x [15:0], src_y [31:16], src_w [39:32], src_h [47:40],
    // dest_x [63:48], dest_y [79:64], dest_w [95:80], dest_h [111:96]
    output logic [bfgl_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_we,
    input  logic [bfgl_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [bfgl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bfgl_pkg::*;

    bfgl_cmd_t cmd;
    bfgl_sts_t sts;

    bfgl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfgl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_start  (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
